// ===== hdl/drnrs_pkg.sv =====
`default_nettype none

package drnrs_pkg;

    // Field widths.
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int ID_W       = 16;
    localparam int ALONG_W    = 17;
    localparam int TOTAL_W    = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default number of entries in the queue between the two halves.
    localparam int QUEUE_DEPTH = 2;

    // This is added to the score of a candidate whose cross projection misses.
    localparam logic [TOTAL_W-1:0] FAR_PENALTY = 21'd1000000;

    // Move direction codes.
    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_X     = 3'd0,
        CFG_CUR_Y     = 3'd1,
        CFG_CUR_W     = 3'd2,
        CFG_CUR_H     = 3'd3,
        CFG_DIRECTION = 3'd4
    } cfg_index_t;

    // A classified candidate, as it travels from the front to the back.
    typedef struct packed {
        logic               first;
        logic               side;
        logic [ALONG_W-1:0] along;
        logic [ALONG_W-1:0] across;
        logic [TOTAL_W-1:0] total;
        logic [ID_W-1:0]    ident;
    } cand_item_t;

endpackage

`default_nettype wire

// ===== hdl/drnrs_front.sv =====
`default_nettype none

module drnrs_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration writes.
    input  logic                                 cfg_we,
    input  logic [drnrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drnrs_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Candidate input channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 first,
    input  logic [drnrs_pkg::COORD_W-1:0]        cand_x,
    input  logic [drnrs_pkg::COORD_W-1:0]        cand_y,
    input  logic [drnrs_pkg::SIZE_W-1:0]         cand_w,
    input  logic [drnrs_pkg::SIZE_W-1:0]         cand_h,
    input  logic [drnrs_pkg::ID_W-1:0]           cand_id,
    // Queue write side.
    output logic                                 push,
    output drnrs_pkg::cand_item_t                push_item,
    input  logic                                 queue_full
);
    import drnrs_pkg::*;

    // Configuration registers.
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_y_reg;
    logic [SIZE_W-1:0]  cur_w_reg;
    logic [SIZE_W-1:0]  cur_h_reg;
    dir_t               dir_reg;

    // Stage one: centre differences and overlap, oriented by direction.
    logic [COORD_W:0]   cand_cx;
    logic [COORD_W:0]   cand_cy;
    logic [COORD_W:0]   cur_cx;
    logic [COORD_W:0]   cur_cy;
    logic [COORD_W+1:0] diff_x;
    logic [COORD_W+1:0] diff_y;
    logic [COORD_W:0]   cur_right;
    logic [COORD_W:0]   cur_bottom;
    logic [COORD_W:0]   cand_right;
    logic [COORD_W:0]   cand_bottom;
    logic               overlap_x;
    logic               overlap_y;
    logic               horizontal;
    logic               accept;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_first_reg;
    logic [ID_W-1:0]    s1_ident_reg;
    logic [COORD_W+1:0] s1_along_reg;
    logic [COORD_W+1:0] s1_across_reg;
    logic               s1_negate_reg;
    logic               s1_overlap_reg;

    // Stage two: primary distance, secondary offset and score.
    logic [COORD_W+1:0] along_signed;
    logic [COORD_W+1:0] across_mag;
    logic [ALONG_W-1:0] primary;
    logic [ALONG_W-1:0] secondary;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_w_reg <= SIZE_W'(1);
            cur_h_reg <= SIZE_W'(1);
            dir_reg   <= DIR_LEFT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CUR_X:     cur_x_reg <= cfg_data[COORD_W-1:0];
                CFG_CUR_Y:     cur_y_reg <= cfg_data[COORD_W-1:0];
                CFG_CUR_W:     cur_w_reg <= cfg_data[SIZE_W-1:0];
                CFG_CUR_H:     cur_h_reg <= cfg_data[SIZE_W-1:0];
                CFG_DIRECTION: dir_reg   <= dir_t'(cfg_data[1:0]);
                default:       ;
            endcase
        end
    end

    // Centres are the edge plus half the size, rounded down.
    always_comb
    begin
        cand_cx = {cand_x[COORD_W-1], cand_x} + {3'b000, cand_w[SIZE_W-1:1]};
        cand_cy = {cand_y[COORD_W-1], cand_y} + {3'b000, cand_h[SIZE_W-1:1]};
        cur_cx  = {cur_x_reg[COORD_W-1], cur_x_reg} + {3'b000, cur_w_reg[SIZE_W-1:1]};
        cur_cy  = {cur_y_reg[COORD_W-1], cur_y_reg} + {3'b000, cur_h_reg[SIZE_W-1:1]};
        diff_x  = {cand_cx[COORD_W], cand_cx} - {cur_cx[COORD_W], cur_cx};
        diff_y  = {cand_cy[COORD_W], cand_cy} - {cur_cy[COORD_W], cur_cy};
    end

    // Projection overlap on each axis, with strict inequalities.
    always_comb
    begin
        cur_right   = {cur_x_reg[COORD_W-1], cur_x_reg} + {2'b00, cur_w_reg};
        cur_bottom  = {cur_y_reg[COORD_W-1], cur_y_reg} + {2'b00, cur_h_reg};
        cand_right  = {cand_x[COORD_W-1], cand_x} + {2'b00, cand_w};
        cand_bottom = {cand_y[COORD_W-1], cand_y} + {2'b00, cand_h};
        overlap_x   = ($signed({cand_x[COORD_W-1], cand_x}) < $signed(cur_right)) &&
                      ($signed(cand_right) > $signed({cur_x_reg[COORD_W-1], cur_x_reg}));
        overlap_y   = ($signed({cand_y[COORD_W-1], cand_y}) < $signed(cur_bottom)) &&
                      ($signed(cand_bottom) > $signed({cur_y_reg[COORD_W-1], cur_y_reg}));
        horizontal  = (dir_reg == DIR_LEFT) || (dir_reg == DIR_RIGHT);
    end

    // Stage one holds one item; it drains into the queue whenever there is room.
    assign push     = s1_valid_reg && !queue_full;
    assign in_stall = s1_valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg   <= first;
            s1_ident_reg   <= cand_id;
            s1_along_reg   <= horizontal ? diff_x : diff_y;
            s1_across_reg  <= horizontal ? diff_y : diff_x;
            s1_negate_reg  <= (dir_reg == DIR_LEFT) || (dir_reg == DIR_UP);
            s1_overlap_reg <= horizontal ? overlap_y : overlap_x;
        end
    end

    // Orient the primary distance, take the offset magnitude and form the score.
    always_comb
    begin
        along_signed = s1_negate_reg ? (~s1_along_reg + (COORD_W+2)'(1)) : s1_along_reg;
        across_mag   = s1_across_reg[COORD_W+1] ? (~s1_across_reg + (COORD_W+2)'(1)) :
                                                  s1_across_reg;
        primary      = along_signed[ALONG_W-1:0];
        secondary    = across_mag[ALONG_W-1:0];

        push_item.first  = s1_first_reg;
        push_item.side   = !along_signed[COORD_W+1] && (along_signed != '0);
        push_item.along  = primary;
        push_item.across = secondary;
        push_item.ident  = s1_ident_reg;
        if (s1_overlap_reg)
        begin
            push_item.total = {{(TOTAL_W-ALONG_W){1'b0}}, primary};
        end
        else
        begin
            push_item.total = {{(TOTAL_W-ALONG_W){1'b0}}, primary} +
                              {{(TOTAL_W-ALONG_W-1){1'b0}}, secondary, 1'b0} +
                              FAR_PENALTY;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/drnrs_queue.sv =====
`default_nettype none

module drnrs_queue #(
    parameter int DEPTH = drnrs_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  drnrs_pkg::cand_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output drnrs_pkg::cand_item_t head_item
);
    import drnrs_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    cand_item_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full       = (count_reg == COUNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The front never writes into a full queue, and the back never reads an empty one.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < COUNT_W'(DEPTH)))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/drnrs_back.sv =====
`default_nettype none

module drnrs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    // Queue read side.
    input  logic                            head_valid,
    input  drnrs_pkg::cand_item_t           head_item,
    output logic                            pop,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [drnrs_pkg::ID_W-1:0]      best_ident,
    output logic                            in_direction
);
    import drnrs_pkg::*;

    // Kept best.
    logic               have_best_reg;
    logic               have_best_next;
    logic [ID_W-1:0]    best_tag_reg;
    logic [ID_W-1:0]    best_tag_next;
    logic [TOTAL_W-1:0] best_total_reg;
    logic [TOTAL_W-1:0] best_total_next;
    logic [ALONG_W-1:0] best_along_reg;
    logic [ALONG_W-1:0] best_along_next;
    logic [ALONG_W-1:0] best_across_reg;
    logic [ALONG_W-1:0] best_across_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               found_reg;
    logic [ID_W-1:0]    ident_reg;
    logic               in_dir_reg;

    logic               have_eff;
    logic [ID_W-1:0]    tag_eff;
    logic [TOTAL_W-1:0] total_eff;
    logic [ALONG_W-1:0] along_eff;
    logic [ALONG_W-1:0] across_eff;
    logic               better;

    // Take the next item whenever the result register is free or being emptied.
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // A first item clears the kept best before it is compared.
    always_comb
    begin
        have_eff   = have_best_reg && !head_item.first;
        tag_eff    = head_item.first ? '0 : best_tag_reg;
        total_eff  = head_item.first ? '0 : best_total_reg;
        along_eff  = head_item.first ? '0 : best_along_reg;
        across_eff = head_item.first ? '0 : best_across_reg;

        better = head_item.side &&
                 (!have_eff || (head_item.total < total_eff) ||
                  ((head_item.total == total_eff) &&
                   ((head_item.along < along_eff) ||
                    ((head_item.along == along_eff) && (head_item.across < across_eff)))));

        have_best_next   = have_best_reg;
        best_tag_next    = best_tag_reg;
        best_total_next  = best_total_reg;
        best_along_next  = best_along_reg;
        best_across_next = best_across_reg;
        if (pop)
        begin
            have_best_next   = better || have_eff;
            best_tag_next    = better ? head_item.ident  : tag_eff;
            best_total_next  = better ? head_item.total  : total_eff;
            best_along_next  = better ? head_item.along  : along_eff;
            best_across_next = better ? head_item.across : across_eff;
        end

        out_valid_next = pop || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg   <= 1'b0;
            best_tag_reg    <= '0;
            best_total_reg  <= '0;
            best_along_reg  <= '0;
            best_across_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            have_best_reg   <= have_best_next;
            best_tag_reg    <= best_tag_next;
            best_total_reg  <= best_total_next;
            best_along_reg  <= best_along_next;
            best_across_reg <= best_across_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // The result payload loads with each item taken from the queue.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg  <= have_best_next;
            ident_reg  <= best_tag_next;
            in_dir_reg <= head_item.side;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign best_ident   = ident_reg;
    assign in_direction = in_dir_reg;

    // A first item that misses the wanted side reports no best and a zero identifier.
    a_first_miss_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.first && !head_item.side) |=> (!found && (best_ident == '0)))
        else $error("search start without a hit left a best behind");

    // The kept best is only dropped by the start of a new search.
    a_best_drops_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(have_best_reg) |-> $past(pop && head_item.first))
        else $error("kept best lost outside a search start");

    // A candidate on the wanted side always leaves a best behind.
    a_hit_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.side) |=> found)
        else $error("candidate on the wanted side left no best");

    // A reported hit is never shown without a best.
    a_dir_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_direction) |-> found)
        else $error("hit reported without a best");

endmodule

`default_nettype wire

// ===== hdl/directional_nearest_rect_select_core.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// cfg       in         cfg_we               cfg_index, cfg_data
// in        in         in_valid / in_stall  first, cand_x, cand_y, cand_w, cand_h, cand_id
// out       out        out_valid / out_stall found, best_ident, in_direction
//
// One candidate is taken per cycle while in_stall is low; the rate is set by the
// combinational compare against the kept best in the back half. From input transfer
// to result, an item passes the classification stage, queue entry and result register.
// Reset clears the configuration to its defaults and drops the kept best.
// A stalled result leaves room for QUEUE_DEPTH + 1 further items before in_stall rises.

module directional_nearest_rect_select_core #(
    parameter int QUEUE_DEPTH = drnrs_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [drnrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drnrs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 first,
    input  logic [drnrs_pkg::COORD_W-1:0]        cand_x,
    input  logic [drnrs_pkg::COORD_W-1:0]        cand_y,
    input  logic [drnrs_pkg::SIZE_W-1:0]         cand_w,
    input  logic [drnrs_pkg::SIZE_W-1:0]         cand_h,
    input  logic [drnrs_pkg::ID_W-1:0]           cand_id,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic [drnrs_pkg::ID_W-1:0]           best_ident,
    output logic                                 in_direction
);
    import drnrs_pkg::*;

    logic       push;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    cand_item_t push_item;
    cand_item_t head_item;

    // Front: configuration and candidate classification.
    drnrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .first      (first),
        .cand_x     (cand_x),
        .cand_y     (cand_y),
        .cand_w     (cand_w),
        .cand_h     (cand_h),
        .cand_id    (cand_id),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // Queue between the two halves.
    drnrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back: best tracking and result register.
    drnrs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .best_ident   (best_ident),
        .in_direction (in_direction)
    );

endmodule

`default_nettype wire
